@@ rtl/core/dtsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dtsc_pkg - deadline thread switch control shared definitions
// Instruction classes, switch phase codes and field widths used by the
// controller and its port checker.
// ----------------------------------------------------------------------------
package dtsc_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PHASE_W = 2;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [PHASE_W-1:0] phase_t;

  // instruction classes
  localparam op_t OP_OTHER    = 2'd0;
  localparam op_t OP_ADD_TASK = 2'd1;
  localparam op_t OP_TASK_END = 2'd2;

  // switch phases
  localparam phase_t PH_RUN       = 2'd0;
  localparam phase_t PH_SAVE_PC   = 2'd1;
  localparam phase_t PH_SAVE_REGS = 2'd2;
  localparam phase_t PH_SAVE_ID   = 2'd3;

  // entry pushed at the head by a task end
  localparam word_t END_TIME = 32'd0;
  localparam word_t END_TAG  = 32'd3;

endpackage

@@ rtl/core/deadline_thread_switch_control_unit.sv @@
// ----------------------------------------------------------------------------
// deadline_thread_switch_control_unit - deadline driven thread switch control
// Ring queue of (release time, tag) task entries and the context switch
// phase sequencer run, save pc, save registers, save id.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock (busy stays low) and shows its
// result after the transfer, held first in the input register, then in
// the result register, with the queue and phase updated at the same edge
// as the result. The result is on the out_ ports for exactly one cycle while
// out_valid is high; the receiver cannot stall, so sample it then. The queue
// is a small memory with one write port; the head entry and the one after it
// are kept in registered read copies, refreshed with write forwarding, so
// the release-time compare and the head outputs never wait on a memory read.
// No clearing pass follows reset: entries are only read while occupied.
// ----------------------------------------------------------------------------
module deadline_thread_switch_control_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  dtsc_pkg::op_t        in_opcode,
  input  dtsc_pkg::word_t      in_task_time,
  input  dtsc_pkg::word_t      in_task_tag,
  input  dtsc_pkg::word_t      in_time_now,
  input  logic                 in_state_enable,
  input  logic                 in_flush,
  // result side
  output logic                 out_valid,
  output dtsc_pkg::phase_t     out_switch_phase,
  output dtsc_pkg::word_t      out_head_time,
  output dtsc_pkg::word_t      out_head_tag,
  output logic                 out_queue_empty,
  output logic                 out_queue_full,
  output logic                 out_push_dropped
);
  import dtsc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  // wrap a pointer forward and back modulo the depth
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input register: the unit never stalls, so every start is a transfer.
  // --------------------------------------------------------------------------
  logic   in_valid_r;
  op_t    op_r;
  word_t  task_time_r;
  word_t  task_tag_r;
  word_t  time_now_r;
  logic   enable_r;
  logic   flush_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r        <= in_opcode;
      task_time_r <= in_task_time;
      task_tag_r  <= in_task_tag;
      time_now_r  <= in_time_now;
      enable_r    <= in_state_enable;
      flush_r     <= in_flush;
    end
  end

  // --------------------------------------------------------------------------
  // Queue state
  // --------------------------------------------------------------------------
  word_t  times_mem [QUEUE_DEPTH];
  word_t  tags_mem  [QUEUE_DEPTH];

  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  logic   pop_pending_r, pop_pending_nxt;
  phase_t phase_r, phase_nxt;

  // registered copies of the entries at head and head + 1
  word_t  head_time_r, head_tag_r;
  word_t  second_time_r, second_tag_r;

  // --------------------------------------------------------------------------
  // Single pass update for the item in the input register
  // --------------------------------------------------------------------------
  logic   add_ok, full_before;
  ptr_t   tail_add, head_pop, head_end;
  logic   empty_add, do_pop, full_mid, empty_mid;
  logic   in_run, end_ok, dropped;
  word_t  cand_time, cand_tag;
  logic   deadline_hit;
  phase_t phase_next;
  logic   mem_we;
  ptr_t   mem_waddr;
  word_t  mem_wtime, mem_wtag;
  ptr_t   rd0_addr, rd1_addr;

  always_comb begin
    in_run      = (phase_r == PH_RUN);

    // append first
    full_before = (ptr_inc(tail_r) == head_r);
    add_ok      = in_valid_r && (op_r == OP_ADD_TASK) && !full_before;
    tail_add    = add_ok ? ptr_inc(tail_r) : tail_r;
    empty_add   = (head_r == tail_add);

    // a pending pop goes ahead of task end in the run phase
    do_pop      = in_valid_r && in_run && pop_pending_r && !empty_add;
    head_pop    = do_pop ? ptr_inc(head_r) : head_r;
    full_mid    = (ptr_inc(tail_add) == head_pop);
    empty_mid   = (head_pop == tail_add);

    end_ok      = in_valid_r && in_run && (op_r == OP_TASK_END) && !full_mid;
    dropped     = in_valid_r && in_run && (op_r == OP_TASK_END) && full_mid;
    head_end    = end_ok ? ptr_dec(head_pop) : head_pop;

    // head entry after append and pop, forwarding this cycle's append
    if (do_pop) begin
      if (add_ok && (tail_r == ptr_inc(head_r))) begin
        cand_time = task_time_r;
        cand_tag  = task_tag_r;
      end else begin
        cand_time = second_time_r;
        cand_tag  = second_tag_r;
      end
    end else begin
      if (add_ok && (tail_r == head_r)) begin
        cand_time = task_time_r;
        cand_tag  = task_tag_r;
      end else begin
        cand_time = head_time_r;
        cand_tag  = head_tag_r;
      end
    end

    deadline_hit = !empty_mid && (time_now_r >= cand_time);

    pop_pending_nxt = pop_pending_r;
    unique case (phase_r)
      PH_RUN: begin
        if (do_pop) begin
          pop_pending_nxt = 1'b0;
        end
        phase_next = (end_ok || deadline_hit) ? PH_SAVE_PC : PH_RUN;
      end
      PH_SAVE_PC:   phase_next = PH_SAVE_REGS;
      PH_SAVE_REGS: phase_next = PH_SAVE_ID;
      PH_SAVE_ID: begin
        phase_next      = PH_RUN;
        pop_pending_nxt = in_valid_r ? 1'b1 : pop_pending_r;
      end
      default:      phase_next = PH_RUN;
    endcase

    // flush wins over everything but the stored entries and the pending pop
    if (in_valid_r && flush_r) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      phase_nxt = PH_RUN;
    end else if (in_valid_r) begin
      head_nxt  = head_end;
      tail_nxt  = tail_add;
      phase_nxt = enable_r ? phase_next : phase_r;
    end else begin
      head_nxt  = head_r;
      tail_nxt  = tail_r;
      phase_nxt = phase_r;
    end

    // one write a cycle: append at tail or task-end entry below head
    mem_we    = add_ok || end_ok;
    mem_waddr = add_ok ? tail_r : head_end;
    mem_wtime = add_ok ? task_time_r : END_TIME;
    mem_wtag  = add_ok ? task_tag_r  : END_TAG;

    rd0_addr  = head_nxt;
    rd1_addr  = ptr_inc(head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      pop_pending_r <= 1'b0;
      phase_r       <= PH_RUN;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      pop_pending_r <= pop_pending_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // entry memory, single write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      times_mem[mem_waddr] <= mem_wtime;
      tags_mem[mem_waddr]  <= mem_wtag;
    end
  end

  // refresh the head copies, forwarding the write of this cycle
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      if (mem_we && (mem_waddr == rd0_addr)) begin
        head_time_r <= mem_wtime;
        head_tag_r  <= mem_wtag;
      end else begin
        head_time_r <= times_mem[rd0_addr];
        head_tag_r  <= tags_mem[rd0_addr];
      end
      if (mem_we && (mem_waddr == rd1_addr)) begin
        second_time_r <= mem_wtime;
        second_tag_r  <= mem_wtag;
      end else begin
        second_time_r <= times_mem[rd1_addr];
        second_tag_r  <= tags_mem[rd1_addr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: state after the cycle
  // --------------------------------------------------------------------------
  logic  res_empty, res_full;
  word_t res_time, res_tag;

  always_comb begin
    res_empty = (head_nxt == tail_nxt);
    res_full  = (ptr_inc(tail_nxt) == head_nxt);
    if (res_empty) begin
      res_time = '0;
      res_tag  = '0;
    end else if (end_ok) begin
      res_time = END_TIME;
      res_tag  = END_TAG;
    end else begin
      res_time = cand_time;
      res_tag  = cand_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_switch_phase <= phase_nxt;
      out_head_time    <= res_time;
      out_head_tag     <= res_tag;
      out_queue_empty  <= res_empty;
      out_queue_full   <= res_full;
      out_push_dropped <= dropped;
    end
  end

endmodule

@@ rtl/core/dtsc_checker.sv @@
// ----------------------------------------------------------------------------
// dtsc_port_checker - port level checks for the thread switch controller
// Result timing and consistency of the queue status seen on the ports.
// ----------------------------------------------------------------------------
module dtsc_port_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              out_valid,
  input  dtsc_pkg::word_t   out_head_time,
  input  dtsc_pkg::word_t   out_head_tag,
  input  logic              out_queue_empty,
  input  logic              out_queue_full
);
  import dtsc_pkg::*;

  // every transfer yields its result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

  // no result without a transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result without a transfer");

  // empty queue shows a zero head entry
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_queue_empty) |-> (out_head_time == '0 && out_head_tag == '0))
    else $error("empty queue with nonzero head entry");

  // queue is never empty and full at once
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_queue_empty && out_queue_full))
    else $error("queue reported empty and full");

endmodule

bind deadline_thread_switch_control_unit dtsc_port_checker u_dtsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_head_time   (out_head_time),
  .out_head_tag    (out_head_tag),
  .out_queue_empty (out_queue_empty),
  .out_queue_full  (out_queue_full)
);

@@ sim/dtsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsc_checker - status checker for the deadline thread switch control unit
// Watches the command and result ports, keeps its own copy of the task ring
// and the switch phase, and compares every status word with its prediction.
// ----------------------------------------------------------------------------
module dtsc_checker #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  dtsc_pkg::op_t     in_opcode,
  input  dtsc_pkg::word_t   in_task_time,
  input  dtsc_pkg::word_t   in_task_tag,
  input  dtsc_pkg::word_t   in_time_now,
  input  logic              in_state_enable,
  input  logic              in_flush,
  input  logic              out_valid,
  input  dtsc_pkg::phase_t  out_switch_phase,
  input  dtsc_pkg::word_t   out_head_time,
  input  dtsc_pkg::word_t   out_head_tag,
  input  logic              out_queue_empty,
  input  logic              out_queue_full,
  input  logic              out_push_dropped,
  output int                n_pending,
  output int                n_errors
);
  import dtsc_pkg::*;

  typedef struct packed {
    phase_t phase;
    word_t  head_time;
    word_t  head_tag;
    logic   empty;
    logic   full;
    logic   dropped;
  } ctl_status_t;

  word_t       ring_time [QUEUE_DEPTH];
  word_t       ring_tag  [QUEUE_DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  logic        pop_owed;
  phase_t      cur_phase;
  ctl_status_t status_due [$];
  int          err_count = 0;

  assign n_pending = status_due.size();
  assign n_errors  = err_count;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // One processor cycle of the controller: append, phase logic, flush.
  task automatic step_controller(input op_t op, input word_t t_time, input word_t t_tag,
                                 input word_t now, input logic en, input logic fl);
    ctl_status_t s;
    phase_t      nxt;
    logic        dropped;
    begin
      nxt     = PH_RUN;
      dropped = 1'b0;
      if (op == OP_ADD_TASK && head_idx != (tail_idx + 1) % QUEUE_DEPTH) begin
        ring_time[tail_idx] = t_time;
        ring_tag[tail_idx]  = t_tag;
        tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
      end
      case (cur_phase)
        PH_RUN: begin
          if (pop_owed && head_idx != tail_idx) begin
            head_idx = (head_idx + 1) % QUEUE_DEPTH;
            pop_owed = 1'b0;
          end
          if (op == OP_TASK_END && head_idx != (tail_idx + 1) % QUEUE_DEPTH) begin
            head_idx = (head_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            ring_time[head_idx] = END_TIME;
            ring_tag[head_idx]  = END_TAG;
            nxt = PH_SAVE_PC;
          end else begin
            if (op == OP_TASK_END) dropped = 1'b1;
            if (head_idx != tail_idx && now >= ring_time[head_idx]) nxt = PH_SAVE_PC;
          end
        end
        PH_SAVE_PC:   nxt = PH_SAVE_REGS;
        PH_SAVE_REGS: nxt = PH_SAVE_ID;
        default: begin
          nxt      = PH_RUN;
          pop_owed = 1'b1;
        end
      endcase
      if (fl) begin
        head_idx  = 0;
        tail_idx  = 0;
        cur_phase = PH_RUN;
      end else if (en) begin
        cur_phase = nxt;
      end
      s.phase     = cur_phase;
      s.empty     = (head_idx == tail_idx);
      s.full      = (head_idx == (tail_idx + 1) % QUEUE_DEPTH);
      s.head_time = s.empty ? '0 : ring_time[head_idx];
      s.head_tag  = s.empty ? '0 : ring_tag[head_idx];
      s.dropped   = dropped;
      status_due.push_back(s);
    end
  endtask

  always @(posedge clk) begin
    ctl_status_t want;
    if (!rst_n) begin
      foreach (ring_time[i]) begin
        ring_time[i] = '0;
        ring_tag[i]  = '0;
      end
      head_idx  = 0;
      tail_idx  = 0;
      pop_owed  = 1'b0;
      cur_phase = PH_RUN;
      status_due.delete();
    end else begin
      if (out_valid) begin
        if (status_due.size() == 0) begin
          $display("%0t: status word with nothing expected, phase %h head %h/%h", $time,
                   out_switch_phase, out_head_time, out_head_tag);
          err_count++;
        end else begin
          want = status_due.pop_front();
          check_field("switch_phase", 32'(want.phase), 32'(out_switch_phase));
          check_field("head_time", want.head_time, out_head_time);
          check_field("head_tag", want.head_tag, out_head_tag);
          check_field("queue_empty", 32'(want.empty), 32'(out_queue_empty));
          check_field("queue_full", 32'(want.full), 32'(out_queue_full));
          check_field("push_dropped", 32'(want.dropped), 32'(out_push_dropped));
        end
      end
      if (start && !busy)
        step_controller(in_opcode, in_task_time, in_task_tag, in_time_now,
                        in_state_enable, in_flush);
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - deadline thread switch control unit
// Drives instruction cycles into the unit: a directed opening that covers the
// field extremes and the queue corner cases, then random traffic shaped to
// fill, drain and flush the task ring. The checker alongside predicts and
// compares every status word; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;
  import dtsc_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int          RAND_ITEMS  = 1600;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 4;
  localparam op_t         OP_RESERVED = 2'd3;

  // traffic modes for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  op_t    in_opcode       = OP_OTHER;
  word_t  in_task_time    = '0;
  word_t  in_task_tag     = '0;
  word_t  in_time_now     = '0;
  logic   in_state_enable = 1'b0;
  logic   in_flush        = 1'b0;
  logic   out_valid;
  phase_t out_switch_phase;
  word_t  out_head_time;
  word_t  out_head_tag;
  logic   out_queue_empty;
  logic   out_queue_full;
  logic   out_push_dropped;
  int     n_pending;
  int     n_errors;
  int     cycle_count = 0;

  // random traffic state
  word_t       clock_base;
  int          mode;
  int          enable_pct;
  bit          no_gaps;
  int unsigned pick;
  op_t         op;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  deadline_thread_switch_control_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_task_time, .in_task_tag, .in_time_now, .in_state_enable, .in_flush,
    .out_valid, .out_switch_phase, .out_head_time, .out_head_tag,
    .out_queue_empty, .out_queue_full, .out_push_dropped
  );

  dtsc_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_task_time, .in_task_tag, .in_time_now, .in_state_enable, .in_flush,
    .out_valid, .out_switch_phase, .out_head_time, .out_head_tag,
    .out_queue_empty, .out_queue_full, .out_push_dropped,
    .n_pending, .n_errors
  );

  // Hard stop: a hung handshake or a lost status word ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Hold start low for gap cycles, then offer one instruction cycle and wait
  // for its transfer. With no gap, start stays high straight into the next one.
  task automatic send_instr(input op_t o, input word_t tt, input word_t tg, input word_t now,
                            input logic en, input logic fl, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode       <= o;
    in_task_time    <= tt;
    in_task_tag     <= tg;
    in_time_now     <= now;
    in_state_enable <= en;
    in_flush        <= fl;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly near the running clock so release times get reached; now and
  // then a full random word or one of the two extremes.
  function automatic word_t pick_word(input word_t base, input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return base + $urandom_range(0, span);
    if (r < 90) return $urandom;
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed opening ---
    // idle cycle on an empty ring, then two entries at the extreme values
    send_instr(OP_OTHER, '0, '0, '0, 1'b1, 1'b0, 0);
    send_instr(OP_ADD_TASK, '1, '1, '0, 1'b1, 1'b0, 0);
    send_instr(OP_ADD_TASK, '0, '0, '0, 1'b1, 1'b0, 0);
    // reach the head release time at the top of the timer range
    send_instr(OP_OTHER, '0, '0, '1, 1'b1, 1'b0, 0);
    // task end outside run is ignored; stall the phase with the enable low
    send_instr(OP_TASK_END, '0, '0, '0, 1'b1, 1'b0, 0);
    send_instr(OP_OTHER, '0, '0, '0, 1'b0, 1'b0, 0);
    send_instr(OP_OTHER, '0, '0, '0, 1'b1, 1'b0, 0);
    send_instr(OP_OTHER, '0, '0, '0, 1'b1, 1'b0, 0);
    // back in run: the owed pop goes first, then a task end pushes at the head
    send_instr(OP_TASK_END, '0, '0, '0, 1'b1, 1'b0, 0);
    // fill the ring while the switch walks its phases
    for (int i = 0; i < int'(QUEUE_DEPTH); i++)
      send_instr(OP_ADD_TASK, word_t'(32'h8000_0000 + i), $urandom, '0, 1'b1, 1'b0, 0);
    // add on a full ring, task end on a full ring, reserved opcode
    send_instr(OP_ADD_TASK, 32'h1234_5678, 32'h9abc_def0, '0, 1'b1, 1'b0, 0);
    send_instr(OP_TASK_END, '0, '0, '0, 1'b1, 1'b0, 0);
    send_instr(OP_RESERVED, '1, '1, '0, 1'b1, 1'b0, 0);
    // flush with the enable low, then a task end into the empty ring
    send_instr(OP_ADD_TASK, '1, '1, '1, 1'b0, 1'b1, 0);
    send_instr(OP_TASK_END, '0, '0, '0, 1'b1, 1'b0, 0);

    // --- random traffic ---
    clock_base = $urandom_range(0, 1000);
    mode       = MODE_MIX;
    enable_pct = 92;
    no_gaps    = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // switch the traffic shape every 40 items
      if (n % 40 == 0) begin
        mode       = $urandom_range(MODE_FILL, MODE_MIX);
        enable_pct = ($urandom_range(0, 3) == 0) ? 50 : 92;
        no_gaps    = ($urandom_range(0, 2) == 0);
      end
      // halfway: drop start and let every outstanding status word drain
      if (n == RAND_ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:  op = (pick < 60) ? OP_ADD_TASK : (pick < 70) ? OP_TASK_END :
                         (pick < 73) ? OP_RESERVED : OP_OTHER;
        MODE_DRAIN: op = (pick < 10) ? OP_ADD_TASK : (pick < 15) ? OP_TASK_END :
                         (pick < 18) ? OP_RESERVED : OP_OTHER;
        default:    op = (pick < 30) ? OP_ADD_TASK : (pick < 45) ? OP_TASK_END :
                         (pick < 48) ? OP_RESERVED : OP_OTHER;
      endcase
      clock_base = clock_base + $urandom_range(0, 3);
      send_instr(op,
                 pick_word(clock_base, 60),
                 $urandom,
                 ($urandom_range(0, 99) < 85) ? clock_base : pick_word(clock_base, 0),
                 ($urandom_range(0, 99) < enable_pct),
                 ($urandom_range(0, 199) < 3),
                 no_gaps ? 0 : $urandom_range(0, 17));
    end
    start <= 1'b0;

    // wait out the last status words, then the pipeline depth
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
